### rtl/core/itsc_pkg.sv
// Shared constants, command codes and controller/datapath interface types.
package itsc_pkg;

    localparam int NCH         = 4;
    localparam int WIN         = 5;
    localparam int SMP_W       = 10;
    localparam int SLOT_W      = 3;
    localparam int SM_W        = 18;
    localparam int LV_W        = 17;
    localparam int SUM_W       = 19;
    localparam int DVD_W       = 33;
    localparam int DVS_W       = 19;
    localparam int DCNT_W      = 6;
    localparam int DRV_W       = 17;
    localparam int BIAS_W      = 16;
    localparam int CORR_W      = 13;
    localparam int TICK_W      = 5;
    localparam int STRAIGHT_N  = 20;
    localparam int BIAS_LIMIT  = 2560;
    localparam int CORR_LIMIT  = 5120;
    localparam int OFF_LEVEL   = 10;
    localparam int IN_W        = 40;
    localparam int OUT_W       = 64;

    // Reciprocal scaling: x / 10 for x below 2^22, and 4 * c / 5 for c up to the limit.
    localparam int SM_RECIP    = 3355444;
    localparam int SM_SHIFT    = 25;
    localparam int SMALL_RECIP = 26215;
    localparam int SMALL_SHIFT = 15;

    // Configuration register indexes.
    localparam logic [2:0] REG_FS_LO = 3'd0;
    localparam logic [2:0] REG_FS_LI = 3'd1;
    localparam logic [2:0] REG_FS_RI = 3'd2;
    localparam logic [2:0] REG_FS_RO = 3'd3;
    localparam logic [2:0] REG_BASE  = 3'd4;
    localparam logic [2:0] REG_RUN   = 3'd5;
    localparam logic [2:0] REG_PGAIN = 3'd6;
    localparam logic [2:0] REG_DGAIN = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_SMOOTH, S_SM_MUL, S_NORM, S_NORM_WAIT, S_BIAS_PREP, S_BIAS_DIV,
        S_BIAS_WAIT, S_PD_MUL, S_CORR, S_SMALL, S_MIX
    } t_state;

    typedef enum logic [3:0] {
        CMD_NONE, CMD_LOAD, CMD_SMOOTH, CMD_SM_MUL, CMD_NORM, CMD_LEVEL, CMD_BIAS_PREP,
        CMD_BIAS_DIV, CMD_BIAS_SET, CMD_PD_MUL, CMD_CORR, CMD_SMALL, CMD_MIX
    } t_cmd;

    typedef struct packed {
        t_cmd       cmd;
        logic [1:0] ch;
    } t_ctrl;

    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

### rtl/core/itsc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module itsc_div
    import itsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    logic              r_busy;
    logic [DCNT_W-1:0] r_cnt;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_rem;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    rem_sh;
    logic              ge;

    // One shift and trial subtract.
    always_comb begin
        rem_sh = {r_rem, r_quo[DVD_W-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
    end

    assign o_done     = r_busy && (r_cnt == '0);
    assign o_quotient = r_quo;

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_W'(DVD_W);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Quotient and remainder.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy && r_cnt != '0) begin
            r_quo <= {r_quo[DVD_W-2:0], ge};
            r_rem <= ge ? DVS_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DVS_W-1:0];
        end
    end

endmodule

### rtl/core/itsc_datapath.sv
// Filtering, normalization, bias, PD and wheel mix datapath with its state.
module itsc_datapath
    import itsc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl             i_ctrl,
    output t_status           o_status,
    input  logic [IN_W-1:0]   i_in_data,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_idx,
    input  logic [15:0]       i_cfg_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [OUT_W-1:0]  o_out_data
);

    // Configuration registers.
    logic [SMP_W-1:0] r_fs [NCH];
    logic [6:0]       r_base, r_run;
    logic [15:0]      r_pgain, r_dgain;

    // Tick state.
    logic [SMP_W-1:0]  r_win [NCH][WIN];
    logic [SLOT_W-1:0] r_slot;
    logic [SM_W-1:0]   r_sm [NCH];
    logic signed [BIAS_W-1:0] r_prev;
    logic [TICK_W-1:0] r_ticks;
    logic signed [DRV_W-1:0] r_hl, r_hr;

    // Working registers.
    logic [21:0]       r_snum;
    logic [LV_W-1:0]   r_lv [NCH];
    logic [DVD_W-1:0]  r_prod;
    logic [SUM_W-1:0]  r_sum;
    logic              r_neg, r_off;
    logic signed [BIAS_W-1:0] r_bias;
    logic signed [33:0] r_pp;
    logic signed [34:0] r_dp;
    logic [CORR_W-1:0] r_corr, r_small;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out;

    // Divider hookup.
    logic             div_start, div_done;
    logic [DVD_W-1:0] div_dvd, div_q;
    logic [DVS_W-1:0] div_dvs;

    itsc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dvd),
        .i_divisor  (div_dvs),
        .o_done     (div_done),
        .o_quotient (div_q)
    );

    // Median of the window in row zero by rank counting.
    logic [SMP_W-1:0] med;
    logic [2:0]       rank;
    always_comb begin
        med = '0;
        for (int j = 0; j < WIN; j++) begin
            rank = '0;
            for (int k = 0; k < WIN; k++) begin
                if (r_win[0][k] < r_win[0][j] || (r_win[0][k] == r_win[0][j] && k < j)) begin
                    rank = rank + 1'b1;
                end
            end
            if (rank == 3'(WIN / 2)) begin
                med = r_win[0][j];
            end
        end
    end

    // Per-tick arithmetic feeding the registers and the divider.
    logic [21:0]      sm_num;
    logic [43:0]      sm_prod;
    logic [SM_W-1:0]  sm_q;
    logic [27:0]      small_prod;
    logic [LV_W-1:0]  norm_num;
    logic [SMP_W-1:0] fs_sel;
    logic signed [SUM_W-1:0] diff;
    logic [SUM_W-1:0] absdiff, lsum;
    logic signed [BIAS_W:0]  err;
    logic signed [BIAS_W+1:0] derr;
    logic signed [35:0] pd;
    logic [35:0]        pd_abs;
    logic [23:0]        mag;
    logic [CORR_W-1:0]  corr;
    logic [14:0]        spd;
    logic signed [DRV_W-1:0] drv_l, drv_r;
    logic straight, hold;

    always_comb begin
        sm_num   = 22'({med, 8'd0}) * 22'd3 + 22'(r_sm[0]) * 22'd7;
        // Division by ten as a multiply by the rounded-up reciprocal.
        sm_prod  = 44'(r_snum) * 44'(SM_RECIP);
        sm_q     = sm_prod[SM_SHIFT +: SM_W];
        // Four fifths of the correction, also by reciprocal.
        small_prod = 28'(r_corr) * 28'(SMALL_RECIP);
        norm_num = LV_W'(r_sm[0][SM_W-1:8]) * LV_W'(100);
        fs_sel   = (r_fs[i_ctrl.ch] == '0) ? SMP_W'(1) : r_fs[i_ctrl.ch];
        diff     = $signed({2'b0, r_lv[0]}) - $signed({2'b0, r_lv[3]})
                 + $signed({2'b0, r_lv[1]}) - $signed({2'b0, r_lv[2]});
        absdiff  = diff[SUM_W-1] ? SUM_W'(-diff) : SUM_W'(diff);
        lsum     = SUM_W'(1) + SUM_W'(r_lv[0]) + SUM_W'(r_lv[1])
                 + SUM_W'(r_lv[2]) + SUM_W'(r_lv[3]);
        err      = -(BIAS_W+1)'(r_bias);
        derr     = (BIAS_W+2)'(err) - (BIAS_W+2)'(r_prev);
        pd       = 36'(r_pp) + 36'(r_dp);
        pd_abs   = pd[35] ? 36'(-pd) : 36'(pd);
        mag      = pd_abs[35:12];
        corr     = (mag > 24'(CORR_LIMIT)) ? CORR_W'(CORR_LIMIT) : mag[CORR_W-1:0];
        straight = (r_bias < BIAS_W'(BIAS_LIMIT)) && (r_bias > -BIAS_W'(BIAS_LIMIT));
        hold     = (r_bias == BIAS_W'(BIAS_LIMIT)) || (r_bias == -BIAS_W'(BIAS_LIMIT));
        spd      = {((straight && r_ticks >= TICK_W'(STRAIGHT_N)) ? r_run : r_base), 8'd0};
        if (!r_bias[BIAS_W-1]) begin
            drv_l = $signed(DRV_W'(spd)) - $signed(DRV_W'(r_corr));
            drv_r = $signed(DRV_W'(spd)) + $signed(DRV_W'(r_small));
        end else begin
            drv_l = $signed(DRV_W'(spd)) + $signed(DRV_W'(r_small));
            drv_r = $signed(DRV_W'(spd)) - $signed(DRV_W'(r_corr));
        end
    end

    // Divider operand selection.
    always_comb begin
        div_start = 1'b0;
        div_dvd   = '0;
        div_dvs   = DVS_W'(1);
        case (i_ctrl.cmd)
            CMD_NORM: begin
                div_start = 1'b1;
                div_dvd   = DVD_W'(norm_num);
                div_dvs   = DVS_W'(fs_sel);
            end
            CMD_BIAS_DIV: begin
                div_start = 1'b1;
                div_dvd   = r_prod;
                div_dvs   = r_sum;
            end
            default: begin
            end
        endcase
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs[0] <= SMP_W'(950);
            r_fs[1] <= SMP_W'(940);
            r_fs[2] <= SMP_W'(950);
            r_fs[3] <= SMP_W'(950);
            r_base  <= 7'd30;
            r_run   <= 7'd40;
            r_pgain <= 16'd2458;
            r_dgain <= 16'd819;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_FS_LO: r_fs[0] <= i_cfg_data[SMP_W-1:0];
                REG_FS_LI: r_fs[1] <= i_cfg_data[SMP_W-1:0];
                REG_FS_RI: r_fs[2] <= i_cfg_data[SMP_W-1:0];
                REG_FS_RO: r_fs[3] <= i_cfg_data[SMP_W-1:0];
                REG_BASE:  r_base  <= i_cfg_data[6:0];
                REG_RUN:   r_run   <= i_cfg_data[6:0];
                REG_PGAIN: r_pgain <= i_cfg_data;
                REG_DGAIN: r_dgain <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Windows and smoothed levels; rows rotate after each channel.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NCH; c++) begin
                r_sm[c] <= '0;
                for (int k = 0; k < WIN; k++) begin
                    r_win[c][k] <= '0;
                end
            end
            r_slot <= '0;
        end else begin
            case (i_ctrl.cmd)
                CMD_LOAD: begin
                    for (int c = 0; c < NCH; c++) begin
                        r_win[c][r_slot] <= i_in_data[c*SMP_W +: SMP_W];
                    end
                    r_slot <= (r_slot == SLOT_W'(WIN - 1)) ? '0 : r_slot + 1'b1;
                end
                CMD_SM_MUL: r_sm[0] <= sm_q;
                CMD_LEVEL: begin
                    for (int c = 0; c < NCH; c++) begin
                        r_win[c] <= r_win[(c + 1) % NCH];
                        r_sm[c]  <= r_sm[(c + 1) % NCH];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Control-law state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev  <= '0;
            r_ticks <= '0;
            r_hl    <= '0;
            r_hr    <= '0;
        end else begin
            if (i_ctrl.cmd == CMD_PD_MUL) begin
                r_prev <= err[BIAS_W-1:0];
            end
            if (i_ctrl.cmd == CMD_MIX) begin
                if (straight) begin
                    if (r_ticks < TICK_W'(STRAIGHT_N)) begin
                        r_ticks <= r_ticks + 1'b1;
                    end
                end else if (!hold) begin
                    r_ticks <= '0;
                end
                if (r_off) begin
                    r_hl <= '0;
                    r_hr <= '0;
                end else if (!hold) begin
                    r_hl <= drv_l;
                    r_hr <= drv_r;
                end
            end
        end
    end

    // Working registers of one tick.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.cmd)
            CMD_SMOOTH: r_snum <= sm_num;
            CMD_LEVEL: r_lv[i_ctrl.ch] <= div_q[LV_W-1:0];
            CMD_BIAS_PREP: begin
                r_prod <= DVD_W'(absdiff) * DVD_W'(25600);
                r_neg  <= diff[SUM_W-1];
                r_sum  <= lsum;
                r_off  <= (r_lv[0] < LV_W'(OFF_LEVEL)) && (r_lv[1] < LV_W'(OFF_LEVEL))
                       && (r_lv[2] < LV_W'(OFF_LEVEL)) && (r_lv[3] < LV_W'(OFF_LEVEL));
            end
            CMD_BIAS_SET: r_bias <= r_neg ? -$signed(div_q[BIAS_W-1:0])
                                          : $signed(div_q[BIAS_W-1:0]);
            CMD_PD_MUL: begin
                r_pp <= $signed({1'b0, r_pgain}) * err;
                r_dp <= $signed({1'b0, r_dgain}) * derr;
            end
            CMD_CORR:  r_corr  <= corr;
            CMD_SMALL: r_small <= small_prod[SMALL_SHIFT +: CORR_W];
            default: begin
            end
        endcase
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.cmd == CMD_MIX) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cmd == CMD_MIX) begin
            r_out <= {r_corr, r_bias, r_off,
                      (r_off ? DRV_W'(0) : (hold ? r_hr : drv_r)),
                      (r_off ? DRV_W'(0) : (hold ? r_hl : drv_l))};
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

`ifndef NO_ASSERTIONS
    // The clamp never lets the correction past its limit.
    a_corr_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> r_out[OUT_W-1 -: CORR_W] <= CORR_W'(CORR_LIMIT))
        else $error("correction above limit");
    // The straight counter saturates at its limit.
    a_ticks_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ticks <= TICK_W'(STRAIGHT_N))
        else $error("straight counter overran");
    // An off-track result carries zero drives.
    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out[2*DRV_W]) |-> r_out[2*DRV_W-1:0] == '0)
        else $error("drives not zero while off track");
    // The window slot stays inside the window.
    a_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot < SLOT_W'(WIN))
        else $error("window slot out of range");
`endif

endmodule

### rtl/core/itsc_ctrl.sv
// Sequencer that steps the datapath through one control tick.
module itsc_ctrl
    import itsc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_state     r_state, n_state;
    logic [1:0] r_ch, n_ch;

    // State and channel registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ch    <= '0;
        end else begin
            r_state <= n_state;
            r_ch    <= n_ch;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_ch    = r_ch;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_SMOOTH;
            S_SMOOTH:    n_state = S_SM_MUL;
            S_SM_MUL:    n_state = S_NORM;
            S_NORM:      n_state = S_NORM_WAIT;
            S_NORM_WAIT: begin
                if (i_status.div_done) begin
                    n_ch    = r_ch + 1'b1;
                    n_state = (r_ch == 2'(NCH - 1)) ? S_BIAS_PREP : S_SMOOTH;
                end
            end
            S_BIAS_PREP:  n_state = S_BIAS_DIV;
            S_BIAS_DIV:   n_state = S_BIAS_WAIT;
            S_BIAS_WAIT:  if (i_status.div_done) n_state = S_PD_MUL;
            S_PD_MUL:     n_state = S_CORR;
            S_CORR:       n_state = S_SMALL;
            S_SMALL:      n_state = S_MIX;
            S_MIX:        if (i_status.out_free) n_state = S_IDLE;
            default:      n_state = S_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb begin
        o_ctrl.cmd = CMD_NONE;
        o_ctrl.ch  = r_ch;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) o_ctrl.cmd = CMD_LOAD;
            end
            S_SMOOTH:     o_ctrl.cmd = CMD_SMOOTH;
            S_SM_MUL:     o_ctrl.cmd = CMD_SM_MUL;
            S_NORM:       o_ctrl.cmd = CMD_NORM;
            S_NORM_WAIT:  if (i_status.div_done) o_ctrl.cmd = CMD_LEVEL;
            S_BIAS_PREP:  o_ctrl.cmd = CMD_BIAS_PREP;
            S_BIAS_DIV:   o_ctrl.cmd = CMD_BIAS_DIV;
            S_BIAS_WAIT:  if (i_status.div_done) o_ctrl.cmd = CMD_BIAS_SET;
            S_PD_MUL:     o_ctrl.cmd = CMD_PD_MUL;
            S_CORR:       o_ctrl.cmd = CMD_CORR;
            S_SMALL:      o_ctrl.cmd = CMD_SMALL;
            S_MIX:        if (i_status.out_free) o_ctrl.cmd = CMD_MIX;
            default: begin
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    // The divider only finishes while the sequencer waits for it.
    a_done_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_status.div_done |-> (r_state == S_NORM_WAIT || r_state == S_BIAS_WAIT))
        else $error("divider result with nobody waiting");
    // A channel pass always starts from a fresh channel count.
    a_ch_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> r_ch == '0)
        else $error("channel count not back at zero");
    // An accepted transfer starts the first channel next.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid) |=> r_state == S_SMOOTH)
        else $error("accepted tick did not start");
`endif

endmodule

### rtl/core/inductive_track_steering_control_unit.sv
// Top level of the inductive track steering controller.
//
// Channel   Dir  Handshake                     Payload
// s_axis    in   s_axis_tvalid/s_axis_tready   four 10-bit raw coil readings
// m_axis    out  m_axis_tvalid/m_axis_tready   drives, off-track flag, bias, correction
// cfg       in   i_cfg_we                      register index and write data
//
// A tick leaves the idle state on the accepting edge; then each channel is filtered,
// scaled by ten and normalized on the shared 33-bit divider, and the bias
// division and the PD and mix steps follow before the result is valid.
// Reset is synchronous and restores the control, configuration and filter state; working registers are not reset.
// A result waits in the output register; the next transfer is accepted meanwhile,
// and the tick only stalls at its final step while that register is still full.
module inductive_track_steering_control_unit
    import itsc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    // raw_left_outer, raw_left_inner, raw_right_inner, raw_right_outer
    input  logic [IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    // left_drive, right_drive, off_track, steer_bias, speed_correction
    output logic [OUT_W-1:0] m_axis_tdata,
    input  logic             i_cfg_we,
    input  logic [2:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data
);

    t_ctrl   ctrl;
    t_status status;

    itsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_ctrl     (ctrl)
    );

    itsc_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .o_status    (status),
        .i_in_data   (s_axis_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
